### hw/rtl/mmma_pkg.sv
// shared types and constants for the modular matrix multiply-add block
package mmma_pkg;

  // default sizing
  localparam int MAX_DIM_DEF   = 64;
  localparam int ELEM_BITS_DEF = 32;

  // fixed field widths
  localparam int IDX_BITS   = 6;
  localparam int VAL_BITS   = 32;
  localparam int Q_BITS     = 32;
  localparam int LEN_BITS   = 7;
  localparam int KIND_BITS  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  // item kinds
  typedef enum logic [KIND_BITS-1:0] {
    KIND_WR_A   = 2'd0,
    KIND_WR_B   = 2'd1,
    KIND_WR_C   = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_ADD_EN    = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_RD,
    ST_C_DATA,
    ST_C_WAIT,
    ST_AB_RD,
    ST_AB_DATA,
    ST_P_START,
    ST_P_WAIT,
    ST_OUT
  } state_t;

  // reducer phases
  typedef enum logic [1:0] {
    RED_IDLE,
    RED_RUN,
    RED_FIX
  } red_phase_t;

  // request to the reducer
  typedef struct packed {
    logic start;
    logic neg;
  } red_req_t;

endpackage

### hw/rtl/mmma_ram.sv
// generic single-write, single-read ram with registered read data
module mmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/mmma_modred.sv
// bit-serial reduction of a signed magnitude modulo q, one bit per cycle
module mmma_modred
  import mmma_pkg::*;
#(
  parameter int MAG_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  red_req_t            req,
  input  logic [MAG_BITS-1:0] mag,
  input  logic [Q_BITS-1:0]   q,
  output logic                done,
  output logic [Q_BITS-1:0]   res
);

  localparam int CNT_W = $clog2(MAG_BITS + 1);

  red_phase_t          phase_r, phase_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MAG_BITS-1:0] sh_r, sh_nxt;
  logic [Q_BITS-1:0]   rem_r, rem_nxt;
  logic                neg_r, neg_nxt;
  logic                done_r, done_nxt;
  logic [Q_BITS-1:0]   res_r, res_nxt;
  logic [Q_BITS:0]     trial;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= RED_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  // restoring remainder step, sign fix at the end
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    trial     = {rem_r, sh_r[MAG_BITS-1]};
    case (phase_r)
      RED_IDLE: begin
        if (req.start) begin
          phase_nxt = RED_RUN;
          cnt_nxt   = CNT_W'(MAG_BITS);
          sh_nxt    = mag;
          rem_nxt   = '0;
          neg_nxt   = req.neg;
        end
      end
      RED_RUN: begin
        if (trial >= {1'b0, q}) begin
          rem_nxt = Q_BITS'(trial - {1'b0, q});
        end else begin
          rem_nxt = trial[Q_BITS-1:0];
        end
        sh_nxt  = {sh_r[MAG_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          phase_nxt = RED_FIX;
        end
      end
      RED_FIX: begin
        if (neg_r && (rem_r != '0)) begin
          res_nxt = q - rem_r;
        end else begin
          res_nxt = rem_r;
        end
        done_nxt  = 1'b1;
        phase_nxt = RED_IDLE;
      end
      default: begin
        phase_nxt = RED_IDLE;
      end
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### hw/rtl/modular_matrix_multiply_add.sv
// top level of the modular matrix multiply-add block
// Write items store one element of A, B or the addend C in three on-chip rams.
// A compute item for (row, col) walks the inner dimension, inner_length capped
// at MAX_DIM steps: per step it reads A[row][k] and B[k][col], multiplies them,
// reduces the exact product modulo q in a bit-serial remainder unit, and adds
// it into the running sum, which starts from the reduced addend C when add is
// enabled. Items are taken one at a time, and a finished result stays on the
// output until it is taken. A modulus below two gives result 0. Rams are not
// cleared: read only entries already written.
module modular_matrix_multiply_add
  import mmma_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int ELEM_BITS = ELEM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: row_index[5:0], col_index[11:6], elem_value[43:12], zero fill
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind[1:0]
  input  logic [KIND_BITS-1:0]  in_tuser,
  // out_tdata: out_row[5:0], out_col[11:6], result_value[43:12], zero fill
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [Q_BITS-1:0]     cfg_data
);

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * ELEM_BITS;

  // row/column wrap table
  logic [IW-1:0] wrap_tab [2**IDX_BITS];
  for (genvar g = 0; g < 2**IDX_BITS; g++) begin : g_wrap
    assign wrap_tab[g] = IW'(g % MAX_DIM);
  end

  function automatic logic [AW-1:0] slot(input logic [IW-1:0] r, input logic [IW-1:0] c);
    slot = AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
  endfunction

  // input fields
  logic [IDX_BITS-1:0] in_row, in_col;
  logic [ELEM_BITS-1:0] in_elem;
  kind_t               in_kind;
  logic                in_acc;
  assign in_row  = in_tdata[IDX_BITS-1:0];
  assign in_col  = in_tdata[2*IDX_BITS-1:IDX_BITS];
  assign in_elem = in_tdata[2*IDX_BITS +: ELEM_BITS];
  assign in_kind = kind_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;

  state_t               state_r, state_nxt;
  logic [Q_BITS-1:0]    modulus_r;
  logic [LEN_BITS-1:0]  inner_len_r;
  logic                 add_en_r;
  logic [IW-1:0]        row_r, row_nxt, col_r, col_nxt;
  logic [IDX_BITS-1:0]  orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [LEN_BITS-1:0]  k_r, k_nxt, len_r, len_nxt, len_cap;
  logic [Q_BITS-1:0]    acc_r, acc_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic signed [PW-1:0] prod_full;
  logic [Q_BITS:0]      sum;
  logic [IW-1:0]        k_idx;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= Q_BITS'(2);
      inner_len_r <= LEN_BITS'(1);
      add_en_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODULUS:   modulus_r   <= cfg_data;
        CFG_INNER_LEN: inner_len_r <= cfg_data[LEN_BITS-1:0];
        CFG_ADD_EN:    add_en_r    <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  // element rams
  logic [ELEM_BITS-1:0] a_rd, b_rd, c_rd;
  logic [AW-1:0]        wr_addr;
  assign wr_addr = slot(wrap_tab[in_row], wrap_tab[in_col]);
  assign k_idx   = IW'(k_r);

  mmma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .wr_en(in_acc && (in_kind == KIND_WR_A)), .wr_addr(wr_addr),
    .wr_data(in_elem), .rd_addr(slot(row_r, k_idx)), .rd_data(a_rd)
  );
  mmma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_ram (
    .clk(clk), .wr_en(in_acc && (in_kind == KIND_WR_B)), .wr_addr(wr_addr),
    .wr_data(in_elem), .rd_addr(slot(k_idx, col_r)), .rd_data(b_rd)
  );
  mmma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_c_ram (
    .clk(clk), .wr_en(in_acc && (in_kind == KIND_WR_C)), .wr_addr(wr_addr),
    .wr_data(in_elem), .rd_addr(slot(row_r, col_r)), .rd_data(c_rd)
  );

  // exact signed product of the two ram outputs
  assign prod_full = $signed(a_rd) * $signed(b_rd);

  // reducer source: addend or registered product, split into sign and magnitude
  red_req_t          red_req;
  logic [PW-1:0]     red_src, red_mag;
  logic              red_done;
  logic [Q_BITS-1:0] red_res;
  assign red_src       = (state_r == ST_C_DATA) ? {{ELEM_BITS{c_rd[ELEM_BITS-1]}}, c_rd}
                                                : prod_r;
  assign red_req.neg   = red_src[PW-1];
  assign red_req.start = (state_r == ST_C_DATA) || (state_r == ST_P_START);
  assign red_mag       = red_src[PW-1] ? (~red_src + 1'b1) : red_src;

  mmma_modred #(.MAG_BITS(PW)) u_modred (
    .clk(clk), .rst_n(rst_n), .req(red_req), .mag(red_mag), .q(modulus_r),
    .done(red_done), .res(red_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    k_r    <= k_nxt;
    len_r  <= len_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  // inner length capped at the matrix size
  assign len_cap = ({{(32-LEN_BITS){1'b0}}, inner_len_r} > 32'(MAX_DIM))
                   ? LEN_BITS'(MAX_DIM) : inner_len_r;
  assign sum = {1'b0, acc_r} + {1'b0, red_res};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_kind == KIND_COMPUTE)) begin
          row_nxt  = wrap_tab[in_row];
          col_nxt  = wrap_tab[in_col];
          orow_nxt = in_row;
          ocol_nxt = in_col;
          len_nxt  = len_cap;
          k_nxt    = '0;
          acc_nxt  = '0;
          if (modulus_r < Q_BITS'(2)) begin
            state_nxt = ST_OUT;
          end else if (add_en_r) begin
            state_nxt = ST_C_RD;
          end else if (len_cap == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_AB_RD;
          end
        end
      end
      ST_C_RD: begin
        state_nxt = ST_C_DATA;
      end
      ST_C_DATA: begin
        state_nxt = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (red_done) begin
          acc_nxt   = red_res;
          state_nxt = (len_r == '0) ? ST_OUT : ST_AB_RD;
        end
      end
      ST_AB_RD: begin
        state_nxt = ST_AB_DATA;
      end
      ST_AB_DATA: begin
        prod_nxt  = prod_full;
        state_nxt = ST_P_START;
      end
      ST_P_START: begin
        state_nxt = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (red_done) begin
          if (sum >= {1'b0, modulus_r}) begin
            acc_nxt = Q_BITS'(sum - {1'b0, modulus_r});
          end else begin
            acc_nxt = sum[Q_BITS-1:0];
          end
          k_nxt     = k_r + 1'b1;
          state_nxt = ((k_r + 1'b1) == len_r) ? ST_OUT : ST_AB_RD;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // handshake and result item
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {{(OUT_DATA_W-Q_BITS-2*IDX_BITS){1'b0}}, acc_r, ocol_r, orow_r};

endmodule

### verif/testbench.sv
// self-checking testbench for the modular matrix multiply-add block
module testbench;
  import mmma_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] val;
  } mm_item_t;

  typedef struct {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [31:0] value;
  } mm_elem_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [KIND_BITS-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [Q_BITS-1:0]     cfg_data = '0;

  modular_matrix_multiply_add dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // items waiting to be sent and elements waiting to come back
  mm_item_t pending_items[$];
  mm_elem_t expected_elems[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  // predictor copy of configuration and stores
  logic [31:0] mdl_modulus = 32'd2;
  logic [6:0]  mdl_inner_len = 7'd1;
  logic        mdl_add_en = 1'b0;
  int          mdl_a[64][64];
  int          mdl_b[64][64];
  int          mdl_c[64][64];

  // entries already queued for writing, so no compute reads an unwritten one
  bit gen_a[64][64];
  bit gen_b[64][64];
  bit gen_c[64][64];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint unsigned residue(input longint v, input longint unsigned q);
    longint unsigned mag;
    longint unsigned r;
    if (v < 0) begin
      mag = longint'(0) - v;
      r = mag % q;
      return (r != 0) ? q - r : 0;
    end
    return longint'(v) % q;
  endfunction

  function automatic logic [31:0] matmul_elem(input logic [5:0] row, input logic [5:0] col);
    longint unsigned q;
    longint unsigned acc;
    int              len;
    q = mdl_modulus;
    if (q < 2) return 32'd0;
    len = (mdl_inner_len > 64) ? 64 : mdl_inner_len;
    acc = mdl_add_en ? residue(longint'(mdl_c[row][col]), q) : 0;
    for (int k = 0; k < len; k++)
      acc = (acc + residue(longint'(mdl_a[row][k]) * longint'(mdl_b[k][col]), q)) % q;
    return acc[31:0];
  endfunction

  // driver, with the predictor run on each accepted item
  always @(posedge clk) begin
    mm_item_t it;
    mm_elem_t e;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        case (kind_t'(in_tuser))
          KIND_WR_A: mdl_a[in_tdata[5:0]][in_tdata[11:6]] = int'(in_tdata[43:12]);
          KIND_WR_B: mdl_b[in_tdata[5:0]][in_tdata[11:6]] = int'(in_tdata[43:12]);
          KIND_WR_C: mdl_c[in_tdata[5:0]][in_tdata[11:6]] = int'(in_tdata[43:12]);
          default: begin
            e.row = in_tdata[5:0];
            e.col = in_tdata[11:6];
            e.value = matmul_elem(e.row, e.col);
            expected_elems.push_back(e);
          end
        endcase
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_tdata <= {4'b0, it.val, it.col, it.row};
          in_tuser <= it.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    mm_elem_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_elems.size() == 0) begin
          report($sformatf("unexpected result %h", out_tdata));
        end else begin
          e = expected_elems.pop_front();
          if (out_tdata[5:0] !== e.row)
            report($sformatf("row got %0d want %0d", out_tdata[5:0], e.row));
          if (out_tdata[11:6] !== e.col)
            report($sformatf("col got %0d want %0d", out_tdata[11:6], e.col));
          if (out_tdata[43:12] !== e.value)
            report($sformatf("value at (%0d,%0d) got %0d want %0d",
                             e.row, e.col, out_tdata[43:12], e.value));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(input kind_t kind, input int row, input int col,
                           input logic [31:0] val);
    mm_item_t it;
    it.kind = kind;
    it.row = 6'(row);
    it.col = 6'(col);
    it.val = val;
    if (kind == KIND_WR_A) gen_a[row][col] = 1'b1;
    if (kind == KIND_WR_B) gen_b[row][col] = 1'b1;
    if (kind == KIND_WR_C) gen_c[row][col] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_idx();
    return ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
  endfunction

  // compute item, preceded by writes of every entry it reads that is not yet written
  task automatic push_compute(input int row, input int col);
    int len;
    len = (mdl_inner_len > 64) ? 64 : mdl_inner_len;
    for (int k = 0; k < len; k++) begin
      if (!gen_a[row][k]) push_item(KIND_WR_A, row, k, rand_val());
      if (!gen_b[k][col]) push_item(KIND_WR_B, k, col, rand_val());
    end
    if (mdl_add_en && !gen_c[row][col]) push_item(KIND_WR_C, row, col, rand_val());
    push_item(KIND_COMPUTE, row, col, $urandom);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40)
        push_compute(rand_idx(), rand_idx());
      else
        push_item(kind_t'($urandom_range(2)), rand_idx(), rand_idx(), rand_val());
    end
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MODULUS:   mdl_modulus = val;
      CFG_INNER_LEN: mdl_inner_len = val[6:0];
      CFG_ADD_EN:    mdl_add_en = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_phase(input logic [31:0] q, input int len, input int add, input int mode);
    write_cfg(CFG_MODULUS, q);
    write_cfg(CFG_INNER_LEN, len);
    write_cfg(CFG_ADD_EN, add);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  // hold the sender until every result is back, then let trailing writes settle;
  // checked away from the active edge so the driver's updates have landed
  task automatic drain();
    do @(negedge clk);
    while (pending_items.size() > 0 || in_tvalid || expected_elems.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  // stimulus and phases
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extreme values and indexes, every kind, widest modulus
    set_phase(32'hFFFF_FFFF, 1, 1, 0);
    push_item(KIND_WR_A, 0, 0, 32'h8000_0000);
    push_item(KIND_WR_B, 0, 0, 32'h8000_0000);
    push_item(KIND_WR_C, 0, 0, 32'h7FFF_FFFF);
    push_compute(0, 0);
    push_item(KIND_WR_A, 63, 0, 32'h7FFF_FFFF);
    push_item(KIND_WR_B, 0, 63, 32'h8000_0000);
    push_item(KIND_WR_C, 63, 63, 32'h8000_0000);
    push_compute(63, 63);
    push_item(KIND_WR_A, 1, 0, 32'h0);
    push_item(KIND_WR_B, 0, 1, 32'hFFFF_FFFF);
    push_item(KIND_WR_C, 1, 1, 32'hFFFF_FFFF);
    push_compute(1, 1);
    push_item(KIND_WR_C, 0, 0, 32'h0);
    push_compute(0, 0);
    drain();

    // modulus two with the addend still reduced, one of the products zero
    set_phase(32'd2, 1, 1, 0);
    push_compute(1, 1);
    push_compute(63, 63);
    drain();

    // random phases across settings and idling modes
    set_phase(32'd2, 1, 0, 1);
    push_random(25);
    drain();
    set_phase(32'd0, 3, 1, 2);
    push_random(15);
    drain();
    set_phase(32'd1, 0, 1, 3);
    push_random(15);
    drain();
    set_phase($urandom, 127, 0, 0);
    push_compute(2, 3);
    drain();
    set_phase($urandom | 32'h8000_0000, $urandom_range(1, 4), 1, 1);
    push_random(30);
    drain();
    set_phase($urandom_range(2, 100), 2, 0, 2);
    push_random(30);
    drain();
    set_phase(32'hFFFF_FFFF, 4, 1, 3);
    push_random(30);
    drain();
    set_phase($urandom_range(3, 32'hFFFF), 64, 1, 0);
    push_compute(2, 3);
    drain();
    set_phase(32'd2, 0, 0, 0);
    push_random(15);
    drain();
    set_phase($urandom, $urandom_range(1, 3), $urandom_range(1), 3);
    push_random(20);
    drain();

    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #30000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
